FILE: sv/egcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egcd_pkg;

    localparam int WIDTH     = 16;
    localparam int COEF_W    = WIDTH + 1;
    localparam int CNT_W     = $clog2(WIDTH);
    localparam int S_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WIDTH + 2 * COEF_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD_X,
        ST_UPD_Y,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: sv/extended_gcd_bezout.sv
`timescale 1ns / 1ps
`default_nettype none

// Extended Euclid: for each input beat (a, b) returns gcd(a, b) and signed
// coefficients x, y with a*x + b*y = gcd; b = 0 gives (a, 1, 0). One item is
// in flight at a time: s_tready is high only while idle. Each Euclid step runs
// a restoring serial divider (one quotient bit per cycle), then uses one shared
// multiplier for the x and y updates in turn. An item takes up to about
// 1.44 * WIDTH steps. The result is held on m_tdata until taken.
module extended_gcd_bezout (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // operand_a, operand_b
    input  wire  [egcd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // gcd_value, coeff_x, coeff_y
    output logic [egcd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int W  = egcd_pkg::WIDTH;
    localparam int CW = egcd_pkg::COEF_W;

    egcd_pkg::state_t state_reg, state_next;

    logic [W-1:0]                  a_reg, a_next;
    logic [W-1:0]                  b_reg, b_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  dvd_reg, dvd_next;
    logic [egcd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]                 xp_reg, xp_next;
    logic [CW-1:0]                 xc_reg, xc_next;
    logic [CW-1:0]                 yp_reg, yp_next;
    logic [CW-1:0]                 yc_reg, yc_next;
    logic [CW-1:0]                 tmp_reg, tmp_next;

    logic [W:0]      trial;
    logic            trial_ge;
    logic [CW-1:0]   mul_coef;
    logic [CW-1:0]   mul_base;
    logic [CW-1:0]   prod;
    logic [CW-1:0]   coef_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= egcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        cnt_reg <= cnt_next;
        xp_reg  <= xp_next;
        xc_reg  <= xc_next;
        yp_reg  <= yp_next;
        yc_reg  <= yc_next;
        tmp_reg <= tmp_next;
    end

    // shared divider step and coefficient multiplier
    assign trial    = {rem_reg, dvd_reg[W-1]};
    assign trial_ge = trial >= {1'b0, b_reg};
    assign mul_coef = (state_reg == egcd_pkg::ST_UPD_X) ? xc_reg : yc_reg;
    assign mul_base = (state_reg == egcd_pkg::ST_UPD_X) ? xp_reg : yp_reg;
    assign prod     = CW'(dvd_reg) * mul_coef;
    assign coef_new = mul_base - prod;

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cnt_next   = cnt_reg;
        xp_next    = xp_reg;
        xc_next    = xc_reg;
        yp_next    = yp_reg;
        yc_next    = yc_reg;
        tmp_next   = tmp_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            egcd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    a_next   = s_tdata[W-1:0];
                    b_next   = s_tdata[2*W-1:W];
                    dvd_next = s_tdata[W-1:0];
                    rem_next = '0;
                    cnt_next = '0;
                    xp_next  = CW'(1);
                    xc_next  = '0;
                    yp_next  = '0;
                    yc_next  = CW'(1);
                    if (s_tdata[2*W-1:W] == '0) begin
                        state_next = egcd_pkg::ST_DONE;
                    end else begin
                        state_next = egcd_pkg::ST_DIV;
                    end
                end
            end
            egcd_pkg::ST_DIV: begin
                rem_next = trial_ge ? W'(trial - {1'b0, b_reg}) : trial[W-1:0];
                dvd_next = {dvd_reg[W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == egcd_pkg::CNT_W'(W - 1)) begin
                    state_next = egcd_pkg::ST_UPD_X;
                end
            end
            egcd_pkg::ST_UPD_X: begin
                tmp_next   = coef_new;
                state_next = egcd_pkg::ST_UPD_Y;
            end
            egcd_pkg::ST_UPD_Y: begin
                yp_next  = yc_reg;
                yc_next  = coef_new;
                xp_next  = xc_reg;
                xc_next  = tmp_reg;
                a_next   = b_reg;
                b_next   = rem_reg;
                dvd_next = b_reg;
                rem_next = '0;
                cnt_next = '0;
                if (rem_reg == '0) begin
                    state_next = egcd_pkg::ST_DONE;
                end else begin
                    state_next = egcd_pkg::ST_DIV;
                end
            end
            egcd_pkg::ST_DONE: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = egcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tdata = egcd_pkg::M_TDATA_W'({yp_reg, xp_reg, a_reg});

endmodule

`default_nettype wire

FILE: dv/tb_extended_gcd_bezout.sv
`timescale 1ns / 1ps

module tb_extended_gcd_bezout;

    localparam int WIDTH         = egcd_pkg::WIDTH;
    localparam int COEF_W        = egcd_pkg::COEF_W;
    localparam int S_TDATA_W     = egcd_pkg::S_TDATA_W;
    localparam int M_TDATA_W     = egcd_pkg::M_TDATA_W;
    localparam int RANDOM_ITEMS  = 1230;
    localparam int CORNER_ROWS   = 20;
    localparam int SETTLE_CYCLES = 450;

    typedef struct packed {
        logic [WIDTH-1:0]         gcd;
        logic signed [COEF_W-1:0] x;
        logic signed [COEF_W-1:0] y;
    } bezout_t;

    typedef struct packed {
        logic [WIDTH-1:0] opa;
        logic [WIDTH-1:0] opb;
        bit               typed;
        bezout_t          want;
    } op_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_COIN,
        RX_BLOCKY
    } rx_mode_t;

    typedef enum logic [2:0] {
        OPS_ZERO_SIDE,
        OPS_EQUAL,
        OPS_MULTIPLE,
        OPS_SMALL,
        OPS_FIBONACCI,
        OPS_FULL
    } ops_kind_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    bezout_t  bezout_q [$];
    bezout_t  want_res;
    bezout_t  got_res;
    int       errors = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    logic [3:0] rx_phase = '0;

    op_row_t corner_rows [CORNER_ROWS] = '{
        '{16'd0,     16'd0,     1'b1, '{16'd0,     17'sd1, 17'sd0}},
        '{16'd65535, 16'd0,     1'b1, '{16'd65535, 17'sd1, 17'sd0}},
        '{16'd0,     16'd65535, 1'b1, '{16'd65535, 17'sd0, 17'sd1}},
        '{16'd0,     16'd1,     1'b1, '{16'd1,     17'sd0, 17'sd1}},
        '{16'd1,     16'd0,     1'b1, '{16'd1,     17'sd1, 17'sd0}},
        '{16'd1,     16'd1,     1'b1, '{16'd1,     17'sd0, 17'sd1}},
        '{16'd65535, 16'd65535, 1'b1, '{16'd65535, 17'sd0, 17'sd1}},
        '{16'd65535, 16'd1,     1'b1, '{16'd1,     17'sd0, 17'sd1}},
        '{16'd1,     16'd65535, 1'b1, '{16'd1,     17'sd1, 17'sd0}},
        '{16'd46368, 16'd28657, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd28657, 16'd46368, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd65535, 16'd65534, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd65534, 16'd65535, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd32768, 16'd16384, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd16384, 16'd32768, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'hAAAA,  16'h5555,  1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'h5555,  16'hAAAA,  1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd65521, 16'd65519, 1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'd240,   16'd46,    1'b0, '{16'd0,     17'sd0, 17'sd0}},
        '{16'h8000,  16'h7FFF,  1'b0, '{16'd0,     17'sd0, 17'sd0}}
    };

    extended_gcd_bezout dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bezout_t bezout_of(input logic [WIDTH-1:0] opa,
                                          input logic [WIDTH-1:0] opb);
        logic [63:0] rem_hi, rem_lo, quo, rem_nx;
        logic [63:0] xp, xc, xn, yp, yc, yn;
        bezout_t res;
        rem_hi = 64'(opa);
        rem_lo = 64'(opb);
        xp = 64'd1;
        xc = 64'd0;
        yp = 64'd0;
        yc = 64'd1;
        while (rem_lo != 64'd0) begin
            quo    = rem_hi / rem_lo;
            rem_nx = rem_hi - quo * rem_lo;
            xn     = xp - quo * xc;
            yn     = yp - quo * yc;
            rem_hi = rem_lo;
            rem_lo = rem_nx;
            xp     = xc;
            xc     = xn;
            yp     = yc;
            yc     = yn;
        end
        res.gcd = rem_hi[WIDTH-1:0];
        res.x   = xp[COEF_W-1:0];
        res.y   = yp[COEF_W-1:0];
        return res;
    endfunction

    task automatic send_operands(input logic [WIDTH-1:0] opa, input logic [WIDTH-1:0] opb,
                                 input bit typed, input bezout_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({opb, opa});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bezout_q.push_back(typed ? want : bezout_of(opa, opb));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bezout_q.size() != 0) @(posedge aclk);
    endtask

    task automatic pick_operands(output logic [WIDTH-1:0] opa, output logic [WIDTH-1:0] opb);
        ops_kind_t  kind;
        logic [WIDTH-1:0] fa, fb, ft;
        int         steps;
        kind = ops_kind_t'($urandom_range(7) > 5 ? OPS_FULL : $urandom_range(5));
        opa  = WIDTH'($urandom);
        opb  = WIDTH'($urandom);
        case (kind)
            OPS_ZERO_SIDE: begin
                if ($urandom_range(1)) opa = '0;
                else opb = '0;
            end
            OPS_EQUAL: begin
                opb = opa;
            end
            OPS_MULTIPLE: begin
                opb = WIDTH'($urandom_range(1, 300));
                opa = WIDTH'(opb * $urandom_range(0, 65535 / opb));
                if ($urandom_range(1)) {opa, opb} = {opb, opa};
            end
            OPS_SMALL: begin
                opa = WIDTH'($urandom_range(255));
                opb = WIDTH'($urandom_range(255));
            end
            OPS_FIBONACCI: begin
                fa = WIDTH'(1);
                fb = WIDTH'(1);
                steps = $urandom_range(1, 22);
                for (int i = 0; i < steps; i++) begin
                    ft = fa + fb;
                    fa = fb;
                    fb = ft;
                end
                opa = fb;
                opb = fa;
                if ($urandom_range(1)) {opa, opb} = {opb, opa};
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        logic [WIDTH-1:0] opa, opb;
        int sent;
        int burst;
        int gap;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_rows[i]) begin
            send_operands(corner_rows[i].opa, corner_rows[i].opb,
                          corner_rows[i].typed, corner_rows[i].want);
        end
        drain_results();

        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                pick_operands(opa, opb);
                send_operands(opa, opb, 1'b0, '0);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_results();
            end else begin
                gap = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        rx_phase <= rx_phase + 4'd1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(3));
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_SPARSE: m_tready <= ($urandom_range(3) == 0);
            RX_COIN:   m_tready <= 1'($urandom_range(1));
            default:   m_tready <= (rx_phase < 4'd4);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res.gcd = m_tdata[WIDTH-1:0];
            got_res.x   = m_tdata[WIDTH +: COEF_W];
            got_res.y   = m_tdata[WIDTH + COEF_W +: COEF_W];
            if (bezout_q.size() == 0) begin
                $error("unexpected result beat: gcd_value %0d coeff_x %0d coeff_y %0d",
                       got_res.gcd, got_res.x, got_res.y);
                errors++;
            end else begin
                want_res = bezout_q.pop_front();
                if (got_res.gcd !== want_res.gcd) begin
                    $error("gcd_value mismatch: expected %0d, actual %0d",
                           want_res.gcd, got_res.gcd);
                    errors++;
                end
                if (got_res.x !== want_res.x) begin
                    $error("coeff_x mismatch: expected %0d, actual %0d",
                           want_res.x, got_res.x);
                    errors++;
                end
                if (got_res.y !== want_res.y) begin
                    $error("coeff_y mismatch: expected %0d, actual %0d",
                           want_res.y, got_res.y);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/egcd_pkg.sv
sv/extended_gcd_bezout.sv
dv/tb_extended_gcd_bezout.sv
